// ===== design/icmp_echo_pkg.sv =====
// Package: shared constants, operation and result codes, result descriptor for the ICMP echo engine.
package icmp_echo_pkg;

    localparam int BUFFER_BYTES = 512;
    localparam int BUF_ADDR_W   = $clog2(BUFFER_BYTES);
    localparam logic [31:0] TIMEOUT_RESET = 32'd60;
    localparam logic [15:0] SEEN_MAX      = 16'hFFFF;
    localparam logic [7:0]  TYPE_ECHO_REQ = 8'd8;
    localparam logic [7:0]  TYPE_ECHO_REP = 8'd0;

    typedef enum logic [2:0] {
        OP_MSG_BYTE  = 3'd0,
        OP_READ_BYTE = 3'd1,
        OP_TICK      = 3'd2,
        OP_START     = 3'd3,
        OP_CANCEL    = 3'd4
    } op_t;

    typedef enum logic [1:0] {
        KIND_REPLY_BYTE = 2'd0,
        KIND_REQ_BYTE   = 2'd1,
        KIND_REPLY_RDY  = 2'd2,
        KIND_PING_DONE  = 2'd3
    } kind_t;

    // One queued result, or the seed of an 8-byte echo request.
    typedef struct packed {
        kind_t        kind;
        logic [7:0]   data;
        logic         last;
        logic [31:0]  target;
        logic [9:0]   size;
        logic         ok;
        logic [31:0]  rtt;
        logic         from_mem;
        logic         is_req;
        logic [15:0]  csum;
        logic [15:0]  id;
    } res_t;

endpackage

// ===== design/icmp_echo_engine.sv =====
// Top level: ICMP echo responder and single-ping engine with a stream interface.
//
// Each request on the s_ side is one operation (s_tuser): a message byte, a read of the next
// reply byte, a tick, a start ping or a cancel. A request is processed in the cycle it is
// accepted: state updates and the 512-byte message buffer write happen at that edge, and a
// result descriptor is loaded into a one-entry result register (the buffer read for a reply
// byte is registered there too). The descriptor moves into the m_ output register in the next
// cycle when that register is free. Back-to-back message bytes stream at one per cycle while
// the result register does not stall; start ping produces eight request bytes and holds the
// input until the eighth moves out: ready stays low while the first seven bytes move out and
// rises again in the cycle the eighth moves out. Ready is low while the result register holds
// a result that does not leave at this edge. The message buffer needs no clearing: reads
// touch only entries written by the current message.
// Field packing: s_tdata = {peer_address, data_byte}; m_tdata = {round_trip, ping_ok,
// reply_size, target_address, out_byte}; operation in s_tuser, result kind in m_tuser.
module icmp_echo_engine (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [31:0] cfg_wdata,     // timeout_ticks
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,       // [7:0] data_byte, [39:8] peer_address
    input  logic        s_tlast,       // last_byte
    input  logic [2:0]  s_tuser,       // operation
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [87:0] m_tdata,       // [7:0] out_byte, [39:8] target_address,
                                       // [49:40] reply_size, [50] ping_ok,
                                       // [82:51] round_trip, rest zero
    output logic        m_tlast,       // last_out
    output logic [1:0]  m_tuser        // result_kind
);

    localparam int AW = icmp_echo_pkg::BUFFER_BYTES > 0 ? icmp_echo_pkg::BUF_ADDR_W : 1;

    // Message buffer
    logic [7:0] mem [icmp_echo_pkg::BUFFER_BYTES];
    logic [7:0] mem_rd_reg;

    // Engine state
    logic [31:0] timeout_reg;
    logic [15:0] seen_reg, seen_next;
    logic [63:0] hdr_reg, hdr_next;
    logic [15:0] sum_reg, sum_next;
    logic [9:0]  plen_reg, plen_next;
    logic [9:0]  rpos_reg, rpos_next;
    logic        pend_reg, pend_next;
    logic [31:0] rpeer_reg, rpeer_next;
    logic [31:0] tick_reg, tick_next;
    logic        wait_reg, wait_next;
    logic [15:0] pid_reg, pid_next;
    logic [31:0] pstart_reg, pstart_next;

    // Result register and request byte counter
    icmp_echo_pkg::res_t res_reg, res_next;
    logic        res_v_reg, res_v_next;
    logic [2:0]  cnt_reg, cnt_next;

    // Output register
    logic        m_tvalid_reg;
    logic [87:0] m_tdata_reg;
    logic        m_tlast_reg;
    logic [1:0]  m_tuser_reg;

    logic        accept, load, res_done, produce, mem_we;
    icmp_echo_pkg::op_t op;
    logic [7:0]  in_byte;
    logic [31:0] in_peer;

    // Message byte path
    logic [15:0] pos;
    logic [15:0] addend;
    logic [16:0] sum_wide;
    logic [15:0] sum_add, sum_base, csum_msg;
    logic [9:0]  kept;
    logic [31:0] tick_inc;
    logic [16:0] req_wide;
    logic [15:0] req_csum;
    logic [7:0]  req_byte, out_byte;

    assign op      = icmp_echo_pkg::op_t'(s_tuser);
    assign in_byte = s_tdata[7:0];
    assign in_peer = s_tdata[39:8];
    assign pos     = seen_reg;

    // Hand the result register to the output whenever the output is free.
    assign load     = res_v_reg && (!m_tvalid_reg || m_tready);
    assign res_done = load && (!res_reg.is_req || cnt_reg == 3'd7);
    assign s_tready = !res_v_reg || res_done;
    assign accept   = s_tvalid && s_tready;

    assign sum_base = (pos == 16'd0) ? 16'd0 : sum_reg;
    assign addend   = pos[0] ? {8'h00, in_byte} : {in_byte, 8'h00};
    assign sum_wide = {1'b0, sum_base} + {1'b0, addend};
    // End-around carry keeps the one's-complement sum folded at every byte.
    assign sum_add  = sum_wide[15:0] + {15'd0, sum_wide[16]};
    assign tick_inc = tick_reg + 32'd1;

    // Start ping checksum: type 8, id byte-swapped, sequence 1.
    assign req_wide = {1'b0, 16'h0900} + {1'b0, tick_reg[7:0], tick_reg[15:8]};
    assign req_csum = ~(req_wide[15:0] + {15'd0, req_wide[16]});

    always_comb begin
        seen_next   = seen_reg;
        hdr_next    = hdr_reg;
        sum_next    = sum_reg;
        plen_next   = plen_reg;
        rpos_next   = rpos_reg;
        pend_next   = pend_reg;
        rpeer_next  = rpeer_reg;
        tick_next   = tick_reg;
        wait_next   = wait_reg;
        pid_next    = pid_reg;
        pstart_next = pstart_reg;
        res_next    = res_reg;
        produce     = 1'b0;
        mem_we      = 1'b0;
        csum_msg    = 16'd0;
        kept        = 10'd0;
        res_next.from_mem = 1'b0;
        res_next.is_req   = 1'b0;
        if (accept) begin
            res_next.data   = 8'd0;
            res_next.last   = 1'b0;
            res_next.target = 32'd0;
            res_next.size   = 10'd0;
            res_next.ok     = 1'b0;
            res_next.rtt    = 32'd0;
            res_next.csum   = 16'd0;
            res_next.id     = 16'd0;
            case (op)
                icmp_echo_pkg::OP_MSG_BYTE: begin
                    if (pos == 16'd0) begin
                        hdr_next  = {56'd0, in_byte};
                        sum_next  = 16'd0;
                        pend_next = 1'b0;
                        rpos_next = 10'd0;
                    end else if (pos < 16'd8) begin
                        hdr_next[pos[2:0]*8 +: 8] = in_byte;
                    end
                    if (pos < 16'(icmp_echo_pkg::BUFFER_BYTES)) begin
                        mem_we = 1'b1;
                        if (pos >= 16'd4) sum_next = sum_add;
                    end
                    if (seen_reg != icmp_echo_pkg::SEEN_MAX) seen_next = seen_reg + 16'd1;
                    csum_msg = ~sum_next;
                    kept = (seen_next < 16'(icmp_echo_pkg::BUFFER_BYTES)) ?
                           seen_next[9:0] : 10'(icmp_echo_pkg::BUFFER_BYTES);
                    if (s_tlast) begin
                        seen_next = 16'd0;
                        if (seen_reg >= 16'd7) begin
                            if (hdr_next[7:0] == icmp_echo_pkg::TYPE_ECHO_REQ) begin
                                // Reply header: type echo reply, code zero, fresh checksum.
                                hdr_next[31:0] = {csum_msg[7:0], csum_msg[15:8], 8'd0,
                                                  icmp_echo_pkg::TYPE_ECHO_REP};
                                plen_next  = kept;
                                rpos_next  = 10'd0;
                                pend_next  = 1'b1;
                                rpeer_next = in_peer;
                                produce    = 1'b1;
                                res_next.kind   = icmp_echo_pkg::KIND_REPLY_RDY;
                                res_next.target = in_peer;
                                res_next.size   = kept;
                            end else if (hdr_next[7:0] == icmp_echo_pkg::TYPE_ECHO_REP &&
                                         wait_reg && hdr_next[47:32] == pid_reg &&
                                         hdr_next[63:48] == 16'd1) begin
                                wait_next = 1'b0;
                                produce   = 1'b1;
                                res_next.kind = icmp_echo_pkg::KIND_PING_DONE;
                                res_next.ok   = 1'b1;
                                res_next.rtt  = tick_reg - pstart_reg;
                            end
                        end
                    end
                end
                icmp_echo_pkg::OP_READ_BYTE: begin
                    if (pend_reg) begin
                        produce = 1'b1;
                        res_next.kind   = icmp_echo_pkg::KIND_REPLY_BYTE;
                        res_next.target = rpeer_reg;
                        res_next.from_mem = (rpos_reg >= 10'd8);
                        res_next.data   = hdr_reg[rpos_reg[2:0]*8 +: 8];
                        res_next.last   = (rpos_reg + 10'd1 >= plen_reg);
                        if (rpos_reg + 10'd1 >= plen_reg) begin
                            pend_next = 1'b0;
                            rpos_next = 10'd0;
                        end else begin
                            rpos_next = rpos_reg + 10'd1;
                        end
                    end
                end
                icmp_echo_pkg::OP_TICK: begin
                    tick_next = tick_inc;
                    if (wait_reg && (tick_inc - pstart_reg) >= timeout_reg) begin
                        wait_next = 1'b0;
                        produce   = 1'b1;
                        res_next.kind = icmp_echo_pkg::KIND_PING_DONE;
                    end
                end
                icmp_echo_pkg::OP_START: begin
                    wait_next   = 1'b1;
                    pid_next    = tick_reg[15:0];
                    pstart_next = tick_reg;
                    produce     = 1'b1;
                    res_next.kind   = icmp_echo_pkg::KIND_REQ_BYTE;
                    res_next.is_req = 1'b1;
                    res_next.target = in_peer;
                    res_next.csum   = req_csum;
                    res_next.id     = tick_reg[15:0];
                end
                icmp_echo_pkg::OP_CANCEL: begin
                    if (wait_reg) begin
                        wait_next = 1'b0;
                        produce   = 1'b1;
                        res_next.kind = icmp_echo_pkg::KIND_PING_DONE;
                    end
                end
                default: begin
                end
            endcase
        end else begin
            res_next.from_mem = res_reg.from_mem;
            res_next.is_req   = res_reg.is_req;
        end
    end

    // Advance the request byte counter; drop the result once its last byte has moved.
    always_comb begin
        res_v_next = res_v_reg;
        cnt_next   = cnt_reg;
        if (load && res_reg.is_req && cnt_reg != 3'd7) begin
            cnt_next = cnt_reg + 3'd1;
        end else if (res_done) begin
            cnt_next   = 3'd0;
            res_v_next = 1'b0;
        end
        if (accept && produce) res_v_next = 1'b1;
    end

    always_comb begin
        case (cnt_reg)
            3'd0:    req_byte = icmp_echo_pkg::TYPE_ECHO_REQ;
            3'd2:    req_byte = res_reg.csum[15:8];
            3'd3:    req_byte = res_reg.csum[7:0];
            3'd4:    req_byte = res_reg.id[7:0];
            3'd5:    req_byte = res_reg.id[15:8];
            3'd6:    req_byte = 8'd1;
            default: req_byte = 8'd0;
        endcase
        if (res_reg.from_mem)    out_byte = mem_rd_reg;
        else if (res_reg.is_req) out_byte = req_byte;
        else                     out_byte = res_reg.data;
    end

    // Message buffer: write on message bytes, registered read on reply reads.
    always_ff @(posedge aclk) begin
        if (mem_we) mem[pos[AW-1:0]] <= in_byte;
        if (accept && op == icmp_echo_pkg::OP_READ_BYTE) mem_rd_reg <= mem[rpos_reg[AW-1:0]];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            timeout_reg  <= icmp_echo_pkg::TIMEOUT_RESET;
            seen_reg     <= 16'd0;
            hdr_reg      <= 64'd0;
            sum_reg      <= 16'd0;
            plen_reg     <= 10'd0;
            rpos_reg     <= 10'd0;
            pend_reg     <= 1'b0;
            rpeer_reg    <= 32'd0;
            tick_reg     <= 32'd0;
            wait_reg     <= 1'b0;
            pid_reg      <= 16'd0;
            pstart_reg   <= 32'd0;
            res_v_reg    <= 1'b0;
            cnt_reg      <= 3'd0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (cfg_we) timeout_reg <= cfg_wdata;
            seen_reg   <= seen_next;
            hdr_reg    <= hdr_next;
            sum_reg    <= sum_next;
            plen_reg   <= plen_next;
            rpos_reg   <= rpos_next;
            pend_reg   <= pend_next;
            rpeer_reg  <= rpeer_next;
            tick_reg   <= tick_next;
            wait_reg   <= wait_next;
            pid_reg    <= pid_next;
            pstart_reg <= pstart_next;
            res_v_reg  <= res_v_next;
            cnt_reg    <= cnt_next;
            if (load)          m_tvalid_reg <= 1'b1;
            else if (m_tready) m_tvalid_reg <= 1'b0;
        end
    end

    // Payload registers: no reset needed.
    always_ff @(posedge aclk) begin
        res_reg <= res_next;
        if (load) begin
            m_tuser_reg <= res_reg.kind;
            m_tlast_reg <= res_reg.is_req ? (cnt_reg == 3'd7) : res_reg.last;
            m_tdata_reg <= {5'd0, res_reg.rtt, res_reg.ok, res_reg.size,
                            res_reg.target, out_byte};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;
    assign m_tuser  = m_tuser_reg;

    // Hold the input while the result register is stuck.
    a_hold_input: assert property (@(posedge aclk) disable iff (!aresetn)
        (res_v_reg && !load) |-> !s_tready) else $error("input taken while result stalled");
    a_cnt_req: assert property (@(posedge aclk) disable iff (!aresetn)
        (cnt_reg != 3'd0) |-> (res_v_reg && res_reg.is_req))
        else $error("request counter running without a request");
    a_pend_len: assert property (@(posedge aclk) disable iff (!aresetn)
        pend_reg |-> (plen_reg >= 10'd8)) else $error("pending reply shorter than header");
    a_start_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && op == icmp_echo_pkg::OP_START) |=> wait_reg)
        else $error("start ping did not arm the wait");

endmodule

// ===== sim/icmp_echo_checker.sv =====
// Checker: predicts ICMP echo engine results from accepted requests and compares them.
`timescale 1ns / 1ps

module icmp_echo_checker
    import icmp_echo_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [31:0] cfg_wdata,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [39:0] s_tdata,
    input  logic        s_tlast,
    input  logic [2:0]  s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [87:0] m_tdata,
    input  logic        m_tlast,
    input  logic [1:0]  m_tuser,
    output int          errors,
    output int          outstanding
);

    typedef struct packed {
        kind_t       kind;
        logic [7:0]  data;
        logic        last;
        logic [31:0] target;
        logic [9:0]  size;
        logic        ok;
        logic [31:0] rtt;
    } echo_result_t;

    echo_result_t awaited[$];

    logic [7:0]  msg_mem [BUFFER_BYTES];
    logic [15:0] seen;
    logic [63:0] hdr;
    logic [31:0] sum;
    logic [9:0]  pend_len;
    logic [9:0]  rd_pos;
    logic        pending;
    logic [31:0] pend_peer;
    logic [31:0] ticks;
    logic        waiting;
    logic [15:0] wait_id;
    logic [31:0] wait_start;
    logic [31:0] timeout;

    function automatic logic [15:0] fold_invert(logic [31:0] s);
        while (s[31:16] != 0)
            s = {16'd0, s[15:0]} + {16'd0, s[31:16]};
        return ~s[15:0];
    endfunction

    function automatic echo_result_t make(kind_t k, logic [7:0] d, logic l, logic [31:0] t,
                                          logic [9:0] sz, logic ok, logic [31:0] rtt);
        echo_result_t r;
        r = '{kind: k, data: d, last: l, target: t, size: sz, ok: ok, rtt: rtt};
        return r;
    endfunction

    task automatic absorb_byte(logic [7:0] b, logic lst, logic [31:0] peer);
        int          pos;
        int          len;
        logic [15:0] cs;
        pos = seen;
        if (pos == 0) begin
            hdr = '0; sum = '0; pending = 0; rd_pos = '0;
        end
        if (pos < 8) hdr[8*pos +: 8] = b;
        if (pos < BUFFER_BYTES) begin
            msg_mem[pos] = b;
            if (pos >= 4) sum = sum + (pos[0] ? {24'd0, b} : {16'd0, b, 8'd0});
        end
        if (seen != SEEN_MAX) seen = seen + 16'd1;
        if (!lst) return;
        len = seen;
        seen = '0;
        if (len < 8) return;
        if (hdr[7:0] == TYPE_ECHO_REQ) begin
            cs = fold_invert(sum);
            hdr[31:0] = {cs[7:0], cs[15:8], 16'd0};
            pend_len = (len < BUFFER_BYTES) ? 10'(len) : 10'(BUFFER_BYTES);
            rd_pos = '0;
            pending = 1;
            pend_peer = peer;
            awaited.push_back(make(KIND_REPLY_RDY, 0, 0, peer, pend_len, 0, 0));
        end else if (hdr[7:0] == TYPE_ECHO_REP && waiting && hdr[47:32] == wait_id
                     && hdr[63:48] == 16'd1) begin
            waiting = 0;
            awaited.push_back(make(KIND_PING_DONE, 0, 0, 0, 0, 1, ticks - wait_start));
        end
    endtask

    task automatic predict(logic [2:0] op, logic [7:0] b, logic lst, logic [31:0] peer);
        logic [7:0]  d;
        logic        fin;
        logic [15:0] cs;
        logic [7:0]  req [8];
        case (op)
            OP_MSG_BYTE: absorb_byte(b, lst, peer);
            OP_READ_BYTE: begin
                if (pending) begin
                    d = (rd_pos < 8) ? hdr[8*rd_pos +: 8] : msg_mem[rd_pos];
                    fin = (rd_pos + 1 >= pend_len);
                    awaited.push_back(make(KIND_REPLY_BYTE, d, fin, pend_peer, 0, 0, 0));
                    if (fin) begin
                        pending = 0; rd_pos = '0;
                    end else begin
                        rd_pos = rd_pos + 10'd1;
                    end
                end
            end
            OP_TICK: begin
                ticks = ticks + 32'd1;
                if (waiting && ticks - wait_start >= timeout) begin
                    waiting = 0;
                    awaited.push_back(make(KIND_PING_DONE, 0, 0, 0, 0, 0, 0));
                end
            end
            OP_START: begin
                // id goes out little-endian, so the sum sees it byte-swapped
                cs = fold_invert(32'h0800 + {16'd0, ticks[7:0], ticks[15:8]} + 32'h0100);
                req = '{TYPE_ECHO_REQ, 8'd0, cs[15:8], cs[7:0], ticks[7:0], ticks[15:8],
                        8'd1, 8'd0};
                for (int k = 0; k < 8; k++)
                    awaited.push_back(make(KIND_REQ_BYTE, req[k], k == 7, peer, 0, 0, 0));
                waiting = 1;
                wait_id = ticks[15:0];
                wait_start = ticks;
            end
            OP_CANCEL: begin
                if (waiting) begin
                    waiting = 0;
                    awaited.push_back(make(KIND_PING_DONE, 0, 0, 0, 0, 0, 0));
                end
            end
            default: ;
        endcase
    endtask

    initial outstanding = 0;

    always @(posedge aclk) begin
        echo_result_t want;
        echo_result_t got;
        if (!aresetn) begin
            seen = '0; hdr = '0; sum = '0; pend_len = '0; rd_pos = '0;
            pending = 0; pend_peer = '0; ticks = '0; waiting = 0; wait_id = '0;
            wait_start = '0; timeout = TIMEOUT_RESET;
            errors = 0;
            awaited.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                got = make(kind_t'(m_tuser), m_tdata[7:0], m_tlast, m_tdata[39:8],
                           m_tdata[49:40], m_tdata[50], m_tdata[82:51]);
                if (awaited.size() == 0) begin
                    $display("%0t: unexpected result %p", $realtime, got);
                    errors = errors + 1;
                end else begin
                    want = awaited.pop_front();
                    if (got !== want || m_tdata[87:83] !== 5'd0) begin
                        $display("%0t: mismatch expected %p actual %p", $realtime, want, got);
                        errors = errors + 1;
                    end
                end
            end
            if (cfg_we) timeout = cfg_wdata;
            if (s_tvalid && s_tready)
                predict(s_tuser, s_tdata[7:0], s_tlast, s_tdata[39:8]);
        end
        outstanding = awaited.size();
    end

endmodule

// ===== sim/tb_top.sv =====
// Testbench top: drives requests into the ICMP echo engine and gives the verdict.
`timescale 1ns / 1ps

module tb_top;
    import icmp_echo_pkg::*;

    // Operation codes the engine must ignore.
    localparam logic [2:0] OP_SPARE_LO = 3'd5;
    localparam logic [2:0] OP_SPARE_HI = 3'd7;
    localparam int         CYCLE_LIMIT = 600000;
    localparam int         RANDOM_ITEMS = 220;

    logic        aclk = 0;
    logic        aresetn = 0;
    logic        cfg_we = 0;
    logic [31:0] cfg_wdata = '0;
    logic        s_tvalid = 0;
    logic        s_tready;
    logic [39:0] s_tdata = '0;
    logic        s_tlast = 0;
    logic [2:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 0;
    logic [87:0] m_tdata;
    logic        m_tlast;
    logic [1:0]  m_tuser;

    int          errors;
    int          outstanding;
    int          cycles = 0;
    int          sent = 0;
    int          stall = 0;
    logic        quiet = 0;      // no idling on either side while set
    logic [31:0] ticks_sent = '0;
    logic [15:0] last_ping_id = '0;

    always begin
        #5 aclk = 1;
        #5 aclk = 0;
    end

    icmp_echo_engine DUT (
        .aclk(aclk), .aresetn(aresetn), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
        .s_tuser(s_tuser), .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tlast(m_tlast), .m_tuser(m_tuser)
    );

    icmp_echo_checker u_checker (
        .aclk(aclk), .aresetn(aresetn), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
        .s_tuser(s_tuser), .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tlast(m_tlast), .m_tuser(m_tuser), .errors(errors), .outstanding(outstanding)
    );

    // Mostly short gaps, now and then a long one.
    function automatic int gap_len();
        int r;
        r = $urandom_range(99);
        if (quiet || r < 60) return 0;
        if (r < 95) return $urandom_range(3, 1);
        return $urandom_range(30, 10);
    endfunction

    // Receiver side: stall the result channel at random.
    always @(posedge aclk) begin
        if (stall > 0) begin
            m_tready <= 0;
            stall <= stall - 1;
        end else begin
            m_tready <= 1;
            stall <= gap_len();
        end
    end

    // Hard stop in case the engine hangs.
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // Present one request and hold it until the engine accepts it.
    task automatic send(logic [2:0] op, logic [7:0] b, logic lst, logic [31:0] peer);
        int g;
        g = gap_len();
        if (g > 0) begin
            s_tvalid <= 0;
            repeat (g) @(posedge aclk);
        end
        s_tvalid <= 1;
        s_tuser  <= op;
        s_tdata  <= {peer, b};
        s_tlast  <= lst;
        do @(posedge aclk); while (!s_tready);
        sent++;
        if (op == OP_TICK) ticks_sent++;
        if (op == OP_START) last_ping_id = ticks_sent[15:0];
    endtask

    // Drop valid, wait until every result is out, let the pipeline drain, write timeout.
    task automatic write_timeout(logic [31:0] v);
        s_tvalid <= 0;
        do @(posedge aclk); while (outstanding != 0);
        repeat (8) @(posedge aclk);
        cfg_we    <= 1;
        cfg_wdata <= v;
        @(posedge aclk);
        cfg_we <= 0;
    endtask

    // Send a message; hdr supplies the first bytes, the rest are random.
    task automatic send_msg(int len, logic [63:0] hdr, int hdr_n, logic [31:0] peer);
        logic [7:0] b;
        for (int i = 0; i < len; i++) begin
            b = (i < hdr_n) ? hdr[8*i +: 8] : 8'($urandom);
            send(OP_MSG_BYTE, b, i == len - 1, peer);
        end
    endtask

    task automatic echo_request(int len);
        send_msg(len, {48'($urandom), 16'h0008}, 2, $urandom);
    endtask

    // Echo reply: type 0, code 0, any checksum, id and sequence little-endian.
    task automatic echo_reply(logic [15:0] id, logic [15:0] seq);
        send_msg(8 + $urandom_range(8), {seq, id, 16'($urandom), 16'h0000}, 8, $urandom);
    endtask

    task automatic read_reply(int n);
        for (int i = 0; i < n; i++)
            send(OP_READ_BYTE, 8'($urandom), 1'($urandom), $urandom);
    endtask

    task automatic ticks(int n);
        for (int i = 0; i < n; i++) send(OP_TICK, 8'($urandom), 1'($urandom), $urandom);
    endtask

    // One randomly chosen scenario; well-formed exchanges dominate.
    task automatic random_scenario();
        int r;
        int len;
        r = $urandom_range(99);
        if (r < 35) begin
            len = ($urandom_range(19) == 0) ? $urandom_range(100, 60) : $urandom_range(24, 8);
            echo_request(len);
            read_reply(($urandom_range(3) == 0) ? $urandom_range(len) : len + 1);
        end else if (r < 55) begin
            send(OP_START, 8'($urandom), 1'($urandom), $urandom);
            ticks($urandom_range(6));
            if ($urandom_range(2) != 0) echo_reply(last_ping_id, 16'd1);
            else echo_reply(last_ping_id ^ 16'($urandom_range(2)), 16'($urandom_range(2)));
        end else if (r < 68) begin
            ticks($urandom_range(12, 1));
        end else if (r < 74) begin
            send(OP_CANCEL, 8'($urandom), 1'($urandom), $urandom);
        end else if (r < 80) begin
            send(3'($urandom_range(OP_SPARE_HI, OP_SPARE_LO)), 8'($urandom), 1'($urandom),
                 $urandom);
        end else if (r < 88) begin
            send_msg($urandom_range(7, 1), 64'($urandom), 1, $urandom);
        end else if (r < 94) begin
            // Other type, possibly cut short by a new message before readout.
            send_msg($urandom_range(16, 8), {32'($urandom), 32'($urandom)}, 8, $urandom);
            read_reply($urandom_range(2));
        end else begin
            echo_request($urandom_range(12, 8));
            read_reply($urandom_range(3));
            echo_request($urandom_range(12, 8));
            read_reply(4);
        end
    endtask

    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // Directed: reads and cancel with nothing pending, spare codes, short message.
        quiet = 1;
        send(OP_READ_BYTE, 8'hFF, 1'b1, 32'hFFFF_FFFF);
        send(OP_CANCEL, 8'h00, 1'b0, 32'h0);
        send(OP_SPARE_LO, 8'hFF, 1'b1, 32'hFFFF_FFFF);
        send(OP_SPARE_HI, 8'h00, 1'b1, 32'h0);
        send_msg(7, 64'h0008, 2, 32'h0A00_0001);
        quiet = 0;
        // Minimal echo request with extreme bytes, read it out and then once more.
        send_msg(8, 64'hFFFF_0000_FFFF_0008, 8, 32'hFFFF_FFFF);
        read_reply(9);
        // Start ping, let it time out at the reset value of the register.
        send(OP_START, 8'hFF, 1'b1, 32'hC0A8_0001);
        ticks(61);
        // Start, replace by a second start, answer it.
        send(OP_START, 8'h00, 1'b0, 32'h0000_0000);
        ticks(2);
        send(OP_START, 8'h55, 1'b0, 32'h8000_0000);
        ticks(3);
        echo_reply(last_ping_id, 16'd1);
        send(OP_START, 8'h00, 1'b0, 32'h1);
        send(OP_CANCEL, 8'h00, 1'b0, 32'h0);

        write_timeout(32'd1);
        for (int n = sent + RANDOM_ITEMS / 3; sent < n; ) random_scenario();
        write_timeout(32'hFFFF_FFFF);
        for (int n = sent + RANDOM_ITEMS / 3; sent < n; ) random_scenario();
        write_timeout(32'd5);
        for (int n = sent + RANDOM_ITEMS / 3; sent < n; ) random_scenario();
        write_timeout(TIMEOUT_RESET);
        quiet = 1;
        for (int n = sent + 40; sent < n; ) random_scenario();
        quiet = 0;

        s_tvalid <= 0;
        do @(posedge aclk); while (outstanding != 0);
        repeat (20) @(posedge aclk);
        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// ===== icmp_echo_engine.f =====
design/icmp_echo_pkg.sv
design/icmp_echo_engine.sv
sim/icmp_echo_checker.sv
sim/tb_top.sv
